>>> hw/rtl/dlfp_pkg.sv
// Package for the delimited length frame parser.
// Holds the parse phases, result kinds and framing constants; no dependencies.
`default_nettype none

package dlfp_pkg;

  localparam logic [7:0]  HDR_BYTE          = 8'hC0;
  localparam logic [15:0] MIN_PACKET_LENGTH = 16'd10;
  localparam logic [15:0] FRAME_OVERHEAD    = 16'd6;
  localparam logic [15:0] MAX_LENGTH_RESET  = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_SKIP    = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_BADLEN   = 2'd2,
    KIND_BADTRAIL = 2'd3
  } kind_t;

endpackage

`default_nettype wire

>>> hw/rtl/delimited_length_frame_parser_unit.sv
// Top level of the delimited length frame parser: byte input register,
// single-pass parse logic and a result register. Uses dlfp_pkg.
//
//   channel  | handshake                    | payload
//   s_       | s_tvalid / s_tready          | s_tdata: rx_byte
//   m_       | m_tvalid / m_tready          | m_tdata, m_tuser, m_tlast
//   cfg_     | cfg_valid / cfg_ready        | cfg_data: max_packet_length
//
// One byte per cycle unless m_tready stalls; each item waits in the input register,
// where the parse logic works on it, and its result goes into the result register.
// Bytes that yield no result are dropped after the parse step.
// A stall on m_tready holds the result and the input register, and backs up
// to s_tready in the same cycle. rst clears all control state synchronously.
`default_nettype none

module delimited_length_frame_parser_unit
  import dlfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] out_length
  output logic [1:0]       m_tuser,   // [1:0] out_kind
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data   // [15:0] max_packet_length
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        adv;

  logic [15:0] max_packet_length;

  phase_t      phase, phase_next;
  logic [23:0] length_accum, length_accum_next;
  logic [1:0]  length_byte_index, length_byte_index_next;
  logic [15:0] payload_remaining, payload_remaining_next;
  logic [15:0] payload_total, payload_total_next;

  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [15:0] res_length;

  logic [15:0] len_low;
  logic        len_high_nz;
  logic        len_bad;
  logic        is_hdr;

  assign adv       = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_packet_length <= cfg_data;
    end
  end

  assign is_hdr      = (in_byte == HDR_BYTE);
  assign len_low     = length_accum[15:0];
  assign len_high_nz = (in_byte != 8'd0) || (length_accum[23:16] != 8'd0);
  assign len_bad     = len_high_nz || (len_low < MIN_PACKET_LENGTH)
                       || (len_low > max_packet_length);

  always_comb begin
    phase_next             = phase;
    length_accum_next      = length_accum;
    length_byte_index_next = length_byte_index;
    payload_remaining_next = payload_remaining;
    payload_total_next     = payload_total;
    res_valid              = 1'b0;
    res_kind               = KIND_PAYLOAD;
    res_byte               = 8'd0;
    res_last               = 1'b0;
    res_length             = 16'd0;
    unique case (phase)
      PH_HUNT: begin
        if (is_hdr) begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (!is_hdr) begin
          length_accum_next      = {16'd0, in_byte};
          length_byte_index_next = 2'd1;
          phase_next             = PH_LEN;
        end
      end
      PH_LEN: begin
        unique case (length_byte_index)
          2'd0: length_accum_next[7:0]   = in_byte;
          2'd1: length_accum_next[15:8]  = in_byte;
          2'd2: length_accum_next[23:16] = in_byte;
          2'd3: length_accum_next        = length_accum;
        endcase
        if (length_byte_index != 2'd3) begin
          length_byte_index_next = length_byte_index + 2'd1;
        end else begin
          length_byte_index_next = 2'd0;
          if (len_bad) begin
            phase_next = PH_HUNT;
            res_valid  = 1'b1;
            res_kind   = KIND_BADLEN;
          end else begin
            payload_total_next     = len_low - FRAME_OVERHEAD;
            payload_remaining_next = len_low - FRAME_OVERHEAD;
            phase_next             = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid = 1'b1;
        res_kind  = KIND_PAYLOAD;
        res_byte  = in_byte;
        res_last  = (payload_remaining <= 16'd1);
        if (res_last) begin
          payload_remaining_next = 16'd0;
          phase_next             = PH_TRAILER;
        end else begin
          payload_remaining_next = payload_remaining - 16'd1;
        end
      end
      PH_TRAILER: begin
        phase_next = PH_HUNT;
        res_valid  = 1'b1;
        res_kind   = is_hdr ? KIND_ACCEPT : KIND_BADTRAIL;
        res_length = payload_total;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      length_accum      <= 24'd0;
      length_byte_index <= 2'd0;
      payload_remaining <= 16'd0;
      payload_total     <= 16'd0;
    end else if (adv) begin
      phase             <= phase_next;
      length_accum      <= length_accum_next;
      length_byte_index <= length_byte_index_next;
      payload_remaining <= payload_remaining_next;
      payload_total     <= payload_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (adv) begin
      m_tdata <= {res_length, res_byte};
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

`ifndef SYNTHESIS
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> payload_remaining != 16'd0)
    else $error("payload phase with no bytes remaining");

  a_len_index: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LEN |-> length_byte_index != 2'd0)
    else $error("length phase with byte index zero");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_PAYLOAD |-> !m_tlast)
    else $error("last flag on a status item");

  a_trailer_follows: assert property (@(posedge clk) disable iff (rst)
    adv && phase == PH_PAYLOAD && res_last |=> phase == PH_TRAILER)
    else $error("last payload byte not followed by trailer phase");
`endif

endmodule

`default_nettype wire
